/* rtl/uer_pkg.sv */
// Shared types and constants for the ultrasonic echo ranger with averaging.
`default_nettype none

package uer_pkg;

	// Widths of the configuration registers, counters and result fields
	localparam int REG_W       = 20;
	localparam int CFG_INDEX_W = 8;
	localparam int COUNT_WIDTH = 16;
	localparam int RUN_W       = 8;
	localparam int AVG_W       = 16;

	// Measurements per run for the long and short modes
	localparam logic [RUN_W-1:0] LONG_RUNS  = RUN_W'(200);
	localparam logic [RUN_W-1:0] SHORT_RUNS = RUN_W'(20);

	// Saturation point of the per-measurement echo counter
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	// Register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_GAP   = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_PULSE = CFG_INDEX_W'(1);

	// Register reset values
	localparam logic [REG_W-1:0] GAP_RESET   = REG_W'(1000);
	localparam logic [REG_W-1:0] PULSE_RESET = REG_W'(10000);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_GAP,
		PH_PULSE,
		PH_WAIT,
		PH_COUNT
	} phase_t;

	typedef struct packed {
		logic start_req;
		logic calibrate;
		logic echo;
	} in_item_t;

	typedef struct packed {
		logic             trigger;
		logic             busy_res;
		logic             done_res;
		logic [AVG_W-1:0] average;
	} out_item_t;

	typedef struct packed {
		logic [REG_W-1:0] gap_ticks;
		logic [REG_W-1:0] pulse_ticks;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/uer_core.sv */
// Measurement sequencer: trigger timing, echo counting and running average.
`default_nettype none

module uer_core (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic step,
	input  uer_pkg::in_item_t  item,
	input  uer_pkg::cfg_t      cfg,
	output uer_pkg::out_item_t result
);
	import uer_pkg::*;

	phase_t                 phase_q, phase_d, cur;
	logic [REG_W-1:0]       timer_q, timer_d, timer_w, timer_inc;
	logic [COUNT_WIDTH-1:0] count_q, count_d, count_w;
	logic [RUN_W-1:0]       runs_q, runs_d, runs_w, runs_inc, run_len;
	logic                   long_q, long_d;
	// Running total of all echo ticks kept as quotient and remainder by the
	// run length; the total stays below 255 * 65535, so no saturation occurs
	// and the quotient always fits the average field.
	logic [AVG_W-1:0]       quo_q, quo_d, quo_w;
	logic [RUN_W-1:0]       rem_q, rem_d, rem_w;
	logic                   rem_wrap;
	logic [AVG_W-1:0]       avg_q, avg_d;
	logic                   trig, done;

	// State registers, advanced once per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			count_q <= '0;
			runs_q  <= '0;
			long_q  <= 1'b0;
			quo_q   <= '0;
			rem_q   <= '0;
			avg_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			count_q <= count_d;
			runs_q  <= runs_d;
			long_q  <= long_d;
			quo_q   <= quo_d;
			rem_q   <= rem_d;
			avg_q   <= avg_d;
		end
	end

	// Next state and result for the current request
	always_comb begin
		cur     = phase_q;
		long_d  = long_q;
		timer_w = timer_q;
		count_w = count_q;
		runs_w  = runs_q;
		quo_w   = quo_q;
		rem_w   = rem_q;

		// Start a run: clear the counters and fall into the first gap tick
		if (phase_q == PH_IDLE && item.start_req) begin
			cur     = PH_GAP;
			long_d  = item.calibrate;
			timer_w = '0;
			count_w = '0;
			runs_w  = '0;
			quo_w   = '0;
			rem_w   = '0;
		end

		run_len   = long_d ? LONG_RUNS : SHORT_RUNS;
		timer_inc = timer_w + REG_W'(1);
		runs_inc  = runs_w + RUN_W'(1);
		rem_wrap  = (rem_w == run_len - RUN_W'(1));

		phase_d = cur;
		timer_d = timer_w;
		count_d = count_w;
		runs_d  = runs_w;
		quo_d   = quo_w;
		rem_d   = rem_w;
		avg_d   = avg_q;
		trig    = 1'b0;
		done    = 1'b0;

		unique case (cur)
			PH_IDLE: begin
			end
			PH_GAP: begin
				timer_d = timer_inc;
				if (timer_inc >= cfg.gap_ticks) begin
					timer_d = '0;
					phase_d = PH_PULSE;
				end
			end
			PH_PULSE: begin
				trig    = 1'b1;
				timer_d = timer_inc;
				if (timer_inc >= cfg.pulse_ticks) begin
					timer_d = '0;
					phase_d = PH_WAIT;
				end
			end
			PH_WAIT: begin
				// Wait for echo to rise; the rising tick counts one
				if (item.echo) begin
					count_d = COUNT_WIDTH'(1);
					rem_d   = rem_wrap ? '0 : rem_w + RUN_W'(1);
					quo_d   = rem_wrap ? quo_w + AVG_W'(1) : quo_w;
					phase_d = PH_COUNT;
				end
			end
			PH_COUNT: begin
				if (item.echo) begin
					// Count high ticks, hold at the counter maximum
					if (count_w != COUNT_MAX) begin
						count_d = count_w + COUNT_WIDTH'(1);
						rem_d   = rem_wrap ? '0 : rem_w + RUN_W'(1);
						quo_d   = rem_wrap ? quo_w + AVG_W'(1) : quo_w;
					end
				end else begin
					// Echo fell: close this measurement
					count_d = '0;
					if (runs_inc >= run_len) begin
						avg_d   = quo_w;
						done    = 1'b1;
						runs_d  = '0;
						phase_d = PH_IDLE;
					end else begin
						runs_d  = runs_inc;
						timer_d = '0;
						phase_d = PH_GAP;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		result.trigger  = trig;
		result.busy_res = (phase_d != PH_IDLE);
		result.done_res = done;
		result.average  = avg_d;
	end

endmodule

`default_nettype wire

/* rtl/ultrasonic_echo_ranger_avg.sv */
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle; the output register is refilled while
// its current result is taken, so only a stalled output holds the input.
// Each request is one echo sample tick, handled in one pass of the sequencer.
// Reset: asynchronous, active low; idle, average 0, gap 1000, pulse 10000.
`default_nettype none

module ultrasonic_echo_ranger_avg (
	input  wire                logic                             clk,
	input  wire                logic                             arst_n,
	input  wire                logic                             in_valid,
	output logic                                                 in_ready,
	input  uer_pkg::in_item_t                                    in_item,
	output logic                                                 out_valid,
	input  wire                logic                             out_ready,
	output uer_pkg::out_item_t                                   out_item,
	input  wire                logic                             cfg_valid,
	output logic                                                 cfg_ready,
	input  wire                logic [uer_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire                logic [uer_pkg::REG_W-1:0]        cfg_data
);
	import uer_pkg::*;

	cfg_t      cfg_q;
	out_item_t out_item_q;
	out_item_t result;
	logic      out_valid_q;
	logic      step;

	// Configuration writes are always taken; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_ticks   <= GAP_RESET;
			cfg_q.pulse_ticks <= PULSE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GAP:   cfg_q.gap_ticks   <= cfg_data;
				REG_PULSE: cfg_q.pulse_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Accept a request whenever the output register is free or draining
	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	uer_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (in_item),
		.cfg    (cfg_q),
		.result (result)
	);

	// Output register: load on accept, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef SYNTHESIS
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid)
		else $error("accepted request produced no result");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.done_res |-> !out_item.busy_res)
		else $error("done reported while still busy");

	a_trigger_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.trigger |-> out_item.busy_res)
		else $error("trigger driven outside a run");
`endif

endmodule

`default_nettype wire

/* tb/echo_ranger_watch.sv */
// Watcher for the echo ranger: tracks its own copy of the sequencer and checks every result.
`timescale 1ns / 1ps

module echo_ranger_watch (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  uer_pkg::in_item_t               in_item,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  uer_pkg::out_item_t              out_item,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [uer_pkg::REG_W-1:0]       cfg_data,
	output int                              fail_count,
	output int                              results_owed
);
	import uer_pkg::*;

	// Shadow copy of the ranger's settings and sequencer
	logic [REG_W-1:0]       gap_reg;
	logic [REG_W-1:0]       pulse_reg;
	phase_t                 ph;
	logic [REG_W-1:0]       tick_timer;
	logic [COUNT_WIDTH-1:0] echo_width;
	logic [23:0]            width_total;
	logic [RUN_W-1:0]       meas_done;
	logic                   long_run;
	logic [AVG_W-1:0]       held_avg;

	// Pin levels and average owed for each accepted request, oldest first
	out_item_t tick_results[$];
	out_item_t owed;
	out_item_t pin_state;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
		fail_count++;
	endtask

	// Advance the sequencer by one echo tick and return what the pins show after it
	task automatic ranger_tick(input in_item_t req, output out_item_t res);
		logic             trig;
		logic             done;
		logic [RUN_W-1:0] len;
		logic [24:0]      total;
		logic [23:0]      avg;
		trig = 1'b0;
		done = 1'b0;
		// Latch the run length only on a start taken while idle
		if (ph == PH_IDLE && req.start_req) begin
			long_run = req.calibrate;
			width_total = '0;
			meas_done = '0;
			echo_width = '0;
			tick_timer = '0;
			ph = PH_GAP;
		end
		len = long_run ? LONG_RUNS : SHORT_RUNS;
		case (ph)
			PH_GAP: begin
				tick_timer = tick_timer + REG_W'(1);
				if (tick_timer >= gap_reg) begin
					tick_timer = '0;
					ph = PH_PULSE;
				end
			end
			PH_PULSE: begin
				trig = 1'b1;
				tick_timer = tick_timer + REG_W'(1);
				if (tick_timer >= pulse_reg) begin
					tick_timer = '0;
					ph = PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (req.echo) begin
					echo_width = COUNT_WIDTH'(1);
					ph = PH_COUNT;
				end
			end
			PH_COUNT: begin
				if (req.echo) begin
					// Saturate the width counter
					if (echo_width != COUNT_MAX)
						echo_width = echo_width + COUNT_WIDTH'(1);
				end else begin
					// Close the measurement and fold it into the saturating sum
					total = {1'b0, width_total} + 25'(echo_width);
					width_total = (total > 25'hFFFFFF) ? 24'hFFFFFF : total[23:0];
					echo_width = '0;
					meas_done = meas_done + RUN_W'(1);
					if (meas_done >= len) begin
						avg = width_total / 24'(len);
						held_avg = (avg > 24'hFFFF) ? 16'hFFFF : avg[15:0];
						done = 1'b1;
						meas_done = '0;
						ph = PH_IDLE;
					end else begin
						tick_timer = '0;
						ph = PH_GAP;
					end
				end
			end
			default: ph = PH_IDLE;
		endcase
		res.trigger = trig;
		res.busy_res = (ph != PH_IDLE);
		res.done_res = done;
		res.average = held_avg;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_reg = GAP_RESET;
			pulse_reg = PULSE_RESET;
			ph = PH_IDLE;
			tick_timer = '0;
			echo_width = '0;
			width_total = '0;
			meas_done = '0;
			long_run = 1'b0;
			held_avg = '0;
			fail_count = 0;
			tick_results.delete();
			results_owed <= 0;
		end else begin
			// Check the result taken at this edge against the oldest owed one
			if (out_valid && out_ready) begin
				if (tick_results.size() == 0) begin
					report_mismatch("result with no request", out_item.average, 0);
				end else begin
					owed = tick_results.pop_front();
					if (out_item.trigger !== owed.trigger)
						report_mismatch("trigger", out_item.trigger, owed.trigger);
					if (out_item.busy_res !== owed.busy_res)
						report_mismatch("busy_res", out_item.busy_res, owed.busy_res);
					if (out_item.done_res !== owed.done_res)
						report_mismatch("done_res", out_item.done_res, owed.done_res);
					if (out_item.average !== owed.average)
						report_mismatch("average", out_item.average, owed.average);
				end
			end
			// Predict the result of each accepted request with the settings it saw
			if (in_valid && in_ready) begin
				ranger_tick(in_item, pin_state);
				tick_results.push_back(pin_state);
			end
			// Update the shadow registers on a register write
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_GAP)
					gap_reg = cfg_data;
				else if (cfg_index == REG_PULSE)
					pulse_reg = cfg_data;
			end
			results_owed <= tick_results.size();
		end
	end

endmodule

/* tb/tb_ultrasonic_echo_ranger_avg.sv */
// Top of the echo ranger testbench: clock, reset, tick stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger_avg;
	import uer_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int FINAL_TICKS = 150;

	typedef enum logic [1:0] {
		SINK_FREE,
		SINK_COIN,
		SINK_RARE,
		SINK_BEAT
	} sink_mode_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	in_item_t               in_item   = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_item_t              out_item;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]       cfg_data  = '0;

	int fail_count;
	int results_owed;

	// Stimulus bookkeeping
	int         burst_left  = 0;
	int         gap_ticks   = 1000;
	int         pulse_ticks = 10000;
	int         n_items     = 0;
	int         n_runs      = 0;
	int         n_long      = 0;
	int         n_cfg       = 0;
	int         quiet_cycles = 0;
	sink_mode_t sink_mode   = SINK_FREE;
	int         mode_left   = 0;
	logic [2:0] beat        = '0;

	ultrasonic_echo_ranger_avg DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	echo_ranger_watch watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_item      (in_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_item     (out_item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit coin();
		return 1'($urandom_range(1, 0));
	endfunction

	// Stall the result side on a pattern that changes now and then
	always @(posedge clk) begin
		if (mode_left == 0) begin
			sink_mode <= sink_mode_t'($urandom_range(3, 0));
			mode_left <= $urandom_range(400, 30);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (sink_mode)
			SINK_FREE: out_ready <= 1'b1;
			SINK_COIN: out_ready <= coin();
			SINK_RARE: out_ready <= ($urandom_range(7, 0) != 0);
			default:   out_ready <= (beat < 3'd5);
		endcase
		beat <= beat + 3'd1;
	end

	// End the run when no channel moves for too long
	always @(posedge clk) begin
		if (arst_n && !((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_ultrasonic_echo_ranger_avg failed");
				$finish;
			end
		end else begin
			quiet_cycles <= 0;
		end
	end

	function automatic bit rare_start();
		return ($urandom_range(7, 0) == 0);
	endfunction

	// Send one echo tick; open an idle gap between bursts
	task automatic send_tick(input bit go, input bit cal, input bit echo_lvl);
		int       idle_len;
		in_item_t req;
		if (burst_left == 0) begin
			burst_left = $urandom_range(80, 1);
			idle_len = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(9, 1);
			if (idle_len != 0) begin
				in_valid <= 1'b0;
				repeat (idle_len) @(posedge clk);
			end
		end
		req.start_req = go;
		req.calibrate = cal;
		req.echo = echo_lvl;
		in_valid <= 1'b1;
		in_item <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		n_items++;
	endtask

	// Drain all results, then write one register
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [REG_W-1:0] val);
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_GAP)
			gap_ticks = (val == '0) ? 1 : int'(val);
		else
			pulse_ticks = (val == '0) ? 1 : int'(val);
		n_cfg++;
	endtask

	// Random ticks; start is held low unless the block is known to be busy
	task automatic noise_ticks(input int count, input bit may_start);
		for (int t = 0; t < count; t++)
			send_tick(may_start && rare_start(), coin(), coin());
	endtask

	// One measurement lined up with the sequencer: gap, pulse, echo delay, echo high, echo low
	task automatic measure_once(input bit opens, input bit cal, input int width, input int lag);
		for (int t = 0; t < gap_ticks + pulse_ticks; t++) begin
			if (opens && t == 0)
				send_tick(1'b1, cal, coin());
			else
				send_tick(rare_start(), coin(), coin());
		end
		for (int t = 0; t < lag; t++)
			send_tick(rare_start(), coin(), 1'b0);
		for (int t = 0; t < width; t++)
			send_tick(rare_start(), coin(), 1'b1);
		send_tick(rare_start(), coin(), 1'b0);
	endtask

	// A whole run of random echo widths and delays
	task automatic run_ranger(input bit cal, input int widest, input int longest_lag);
		int n;
		n = cal ? int'(LONG_RUNS) : int'(SHORT_RUNS);
		for (int m = 0; m < n; m++)
			measure_once(m == 0, cal, $urandom_range(widest, 1),
				$urandom_range(longest_lag, 0));
		n_runs++;
		if (cal)
			n_long++;
	endtask

	initial begin
		// Hold reset, then release it
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle ticks under reset settings, every calibrate and echo level
		for (int k = 0; k < 4; k++)
			send_tick(1'b0, k[1], k[0]);

		// Zero registers act as one tick; first measurement spelled out
		write_reg(REG_GAP, '0);
		write_reg(REG_PULSE, '0);
		send_tick(1'b1, 1'b0, 1'b1);
		send_tick(1'b1, 1'b1, 1'b1);
		send_tick(1'b1, 1'b1, 1'b0);
		send_tick(1'b0, 1'b1, 1'b1);
		send_tick(1'b0, 1'b0, 1'b0);
		for (int m = 1; m < int'(SHORT_RUNS); m++)
			measure_once(1'b0, 1'b0, $urandom_range(6, 1), $urandom_range(3, 0));
		n_runs++;

		// Long run at the shortest legal gap and pulse
		write_reg(REG_GAP, REG_W'(1));
		write_reg(REG_PULSE, REG_W'(1));
		run_ranger(1'b1, 2, 1);

		// Short runs at random settings with noise between them
		for (int r = 0; r < 2; r++) begin
			write_reg(REG_GAP, REG_W'($urandom_range(7, 2)));
			write_reg(REG_PULSE, REG_W'($urandom_range(7, 2)));
			noise_ticks($urandom_range(8, 2), 1'b0);
			run_ranger(1'b0, 6, 3);
		end

		// Largest settings: idle ticks, then a run left deep inside a long pulse
		write_reg(REG_GAP, {REG_W{1'b1}});
		write_reg(REG_PULSE, {REG_W{1'b1}});
		noise_ticks(8, 1'b0);
		write_reg(REG_GAP, REG_W'(2));
		send_tick(1'b1, coin(), coin());
		noise_ticks(FINAL_TICKS, 1'b1);

		// Drain the last results
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent %0d echo ticks; %0d runs finished (%0d long), one left in a long pulse.",
			n_items, n_runs, n_long);
		$display("Wrote %0d registers, zero and full-scale among them.", n_cfg);
		if (fail_count == 0)
			$display("tb_ultrasonic_echo_ranger_avg passed");
		else
			$display("tb_ultrasonic_echo_ranger_avg failed");
		$finish;
	end

endmodule
